// ===== hdl/scdr_pkg.sv =====
// Shared constants, job type and reply length lookup for the command deframer.
package scdr_pkg;

    localparam int BUFFER_BYTES       = 1024;
    localparam int LEGACY_FRAME_BYTES = 10;
    localparam int HELD_W             = $clog2(BUFFER_BYTES + 1);

    localparam logic [7:0] HDR_LEGACY = 8'hFF;
    localparam logic [7:0] HDR_FRAMED = 8'h02;
    localparam logic [7:0] END_FRAMED = 8'h03;
    localparam logic [7:0] CODE_BASE  = 8'h30;
    localparam logic [7:0] LEGACY_R0  = 8'h45;
    localparam logic [7:0] LEGACY_R1  = 8'h30;
    localparam logic [7:0] LEGACY_R2  = 8'h30;

    // Framed frame: header, code, two length bytes, payload, checksum, end byte
    localparam int FRAMED_OVERHEAD = 6;

    localparam int TABLE_SIZE = 30;
    localparam logic [7:0] REPLY_LEN_TABLE [TABLE_SIZE] = '{
        8'd1, 8'd16, 8'd4, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd0,
        8'd0, 8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd1,  8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd24
    };

    // Reply byte counter covers header, code, two length bytes, 255 zeros,
    // checksum and end byte.
    localparam int CNT_W = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       is_legacy;
        logic [7:0] code;
        logic [7:0] len;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    function automatic logic [7:0] reply_len(input logic [7:0] code);
        logic [7:0] idx;
        idx = code - CODE_BASE;
        if (code < CODE_BASE || idx >= 8'(TABLE_SIZE)) begin
            return 8'd0;
        end
        return REPLY_LEN_TABLE[idx[4:0]];
    endfunction

endpackage

// ===== hdl/scdr_front.sv =====
// Front end: parse command words, track the frame, push reply jobs.
module scdr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                req_type,
    input  logic [7:0]          data_byte,
    output scdr_pkg::job_push_t push
);
    import scdr_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEGACY,
        PH_FRAMED
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic [7:0]          code_reg, code_next;
    logic [15:0]         plen_reg, plen_next;
    logic [HELD_W-1:0]   held_inc;
    logic                in_fire;
    logic [7:0]          tbl_len;

    assign in_fire  = in_valid && in_ready;
    assign held_inc = held_reg + HELD_W'(1);
    assign tbl_len  = reply_len(code_reg);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        code_next  = code_reg;
        plen_next  = plen_reg;
        push       = '0;
        if (in_fire) begin
            if (req_type) begin
                // drop any partial frame
                phase_next = PH_HUNT;
                held_next  = '0;
                code_next  = '0;
                plen_next  = '0;
            end else if (phase_reg == PH_HUNT || held_reg == HELD_W'(BUFFER_BYTES)) begin
                // hunt: a full buffer is dropped and this word starts afresh
                phase_next = PH_HUNT;
                held_next  = '0;
                code_next  = '0;
                plen_next  = '0;
                if (data_byte == HDR_LEGACY) begin
                    phase_next = PH_LEGACY;
                    held_next  = HELD_W'(1);
                end else if (data_byte == HDR_FRAMED) begin
                    phase_next = PH_FRAMED;
                    held_next  = HELD_W'(1);
                end
            end else begin
                held_next = held_inc;
                if (phase_reg == PH_FRAMED) begin
                    if (held_inc == HELD_W'(2)) begin
                        code_next = data_byte;
                    end else if (held_inc == HELD_W'(3)) begin
                        plen_next = {data_byte, 8'h00};
                    end else if (held_inc == HELD_W'(4)) begin
                        plen_next = {plen_reg[15:8], data_byte};
                    end
                    if (held_inc >= HELD_W'(FRAMED_OVERHEAD)
                        && 17'(held_inc) == 17'(plen_next) + 17'(FRAMED_OVERHEAD)) begin
                        push.valid         = (tbl_len != 8'd0);
                        push.job.is_legacy = 1'b0;
                        push.job.code      = code_reg;
                        push.job.len       = tbl_len;
                        phase_next = PH_HUNT;
                        held_next  = '0;
                        code_next  = '0;
                        plen_next  = '0;
                    end
                end else if (held_inc >= HELD_W'(LEGACY_FRAME_BYTES)) begin
                    push.valid         = 1'b1;
                    push.job.is_legacy = 1'b1;
                    phase_next = PH_HUNT;
                    held_next  = '0;
                    code_next  = '0;
                    plen_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HUNT;
            held_reg  <= '0;
            code_reg  <= '0;
            plen_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            code_reg  <= code_next;
            plen_reg  <= plen_next;
        end
    end

endmodule

// ===== hdl/scdr_queue.sv =====
// Small job queue between the parser and the reply generator.
module scdr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  scdr_pkg::job_push_t push,
    input  logic                pop,
    output logic                not_full,
    output logic                head_valid,
    output scdr_pkg::job_t      head
);
    import scdr_pkg::*;

    job_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign not_full   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.valid) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/scdr_back.sv =====
// Back end: expand queued jobs into reply words through an output register.
module scdr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  scdr_pkg::job_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     reply_byte,
    output logic           last_byte
);
    import scdr_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             load;
    logic [7:0]       gen_byte;
    logic             gen_last;
    logic [CNT_W-1:0] len_w;
    logic [7:0]       sum;

    assign len_w = CNT_W'(head.len);
    // table lengths fit one byte, so the length high byte is zero
    assign sum   = head.code + head.len;
    assign load  = head_valid && (!out_valid_reg || out_ready);
    assign pop   = load && gen_last;

    always_comb
    begin
        gen_byte = 8'h00;
        gen_last = 1'b0;
        if (head.is_legacy) begin
            case (cnt_reg[1:0])
                2'd0:    gen_byte = LEGACY_R0;
                2'd1:    gen_byte = LEGACY_R1;
                default:
                begin
                    gen_byte = LEGACY_R2;
                    gen_last = 1'b1;
                end
            endcase
        end else begin
            if (cnt_reg == CNT_W'(0)) begin
                gen_byte = HDR_FRAMED;
            end else if (cnt_reg == CNT_W'(1)) begin
                gen_byte = head.code;
            end else if (cnt_reg == CNT_W'(3)) begin
                gen_byte = head.len;
            end else if (cnt_reg == len_w + CNT_W'(4)) begin
                gen_byte = sum;
            end else if (cnt_reg == len_w + CNT_W'(5)) begin
                gen_byte = END_FRAMED;
                gen_last = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            byte_next      = gen_byte;
            last_next      = gen_last;
            cnt_next       = gen_last ? '0 : cnt_reg + CNT_W'(1);
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign reply_byte = byte_reg;
    assign last_byte  = last_reg;

endmodule

// ===== hdl/serial_command_deframer_responder_core.sv =====
// Serial command deframer and responder: top level joining parser, job queue and reply generator.
// Throughput: one input word per cycle; reply words leave at one per cycle while out_ready is
//   high, from a single output register; input stalls only when the four-entry job queue is full.
// Path: the job is written to the queue at the edge that accepts the word completing a frame;
//   the first reply word is registered once that job heads the queue and the output is free.
// Reset: rst_n asynchronous active low; parser returns to hunting, queue and output empty.
module serial_command_deframer_responder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] reply_byte,
    output logic       last_byte
);
    import scdr_pkg::*;

    job_push_t push;
    job_t      head;
    logic      head_valid;
    logic      pop;
    logic      not_full;

    // Accept a word whenever the queue has room for the job it might create;
    // the parser itself can take one word per cycle.
    assign in_ready = not_full;

    // Front: hunt for headers, count held words, capture code and length,
    // and push one job per completed frame that has a reply.
    scdr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_byte (data_byte),
        .push      (push)
    );

    // Queue: decouple parsing from reply emission so each side stalls alone.
    scdr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .not_full   (not_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: walk the head job word by word; pop it as its last word loads.
    scdr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reply_byte (reply_byte),
        .last_byte  (last_byte)
    );

endmodule
